// File: rtl/npc_pkg.sv
// npc_pkg: shared types, codes and helpers of the nearest palette color search
// used by npc_ingress, npc_cell and nearest_palette_color
`default_nettype none

package npc_pkg;

    // default palette depth
    localparam int NPC_PALETTE_ENTRIES = 256;
    // entries reachable through an 8-bit entry index
    localparam int NPC_ADDRESSABLE     = 256;

    localparam int COMP_W  = 6;
    localparam int INDEX_W = 8;
    localparam int DIST_W  = 14;
    localparam int RAW_W   = 9;

    // largest component value after clamping
    localparam logic [COMP_W-1:0] COMP_MAX = 6'd63;
    // first entry that takes part in the search
    localparam logic [INDEX_W-1:0] FIRST_SEARCHED = 8'd1;
    // running distance before any entry is seen, above every real distance
    localparam logic [DIST_W-1:0] DIST_INIT = 14'h3FFF;

    // item kinds
    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    // one beat traveling down the chain of cells
    typedef struct packed {
        logic               vld;
        t_kind              kind;
        logic [INDEX_W-1:0] idx;
        logic [COMP_W-1:0]  red;
        logic [COMP_W-1:0]  green;
        logic [COMP_W-1:0]  blue;
        logic [INDEX_W-1:0] best;
        logic [DIST_W-1:0]  distance;
    } t_item;

    // clamp a signed 9-bit component to 0..63
    function automatic logic [COMP_W-1:0] clamp_comp(input logic signed [RAW_W-1:0] raw);
        logic [COMP_W-1:0] res;
        if (raw[RAW_W-1]) begin
            res = '0;
        end else if (raw[RAW_W-2:COMP_W] != '0) begin
            res = COMP_MAX;
        end else begin
            res = raw[COMP_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/npc_ingress.sv
// npc_ingress: input stage, clamps the components and starts a beat on the chain
// depends on npc_pkg
`default_nettype none

module npc_ingress
    import npc_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic                      i_kind,
    input  wire logic [INDEX_W-1:0]        i_entry_index,
    input  wire logic signed [RAW_W-1:0]   i_red,
    input  wire logic signed [RAW_W-1:0]   i_green,
    input  wire logic signed [RAW_W-1:0]   i_blue,
    output t_item                          o_item
);

    t_item r_item;
    t_item n_item;

    // clamp and seed the running best
    always_comb begin
        n_item.vld      = i_valid;
        n_item.kind     = t_kind'(i_kind);
        n_item.idx      = i_entry_index;
        n_item.red      = clamp_comp(i_red);
        n_item.green    = clamp_comp(i_green);
        n_item.blue     = clamp_comp(i_blue);
        n_item.best     = FIRST_SEARCHED;
        n_item.distance = DIST_INIT;
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

// File: rtl/npc_cell.sv
// npc_cell: one palette entry of the chain, takes writes aimed at it and
// compares passing queries against it; depends on npc_pkg
`default_nettype none

module npc_cell
    import npc_pkg::*;
#(
    parameter int CELL_INDEX = 1
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire t_item  i_item,
    output t_item       o_item
);

    localparam logic [INDEX_W-1:0] MY_INDEX = CELL_INDEX[INDEX_W-1:0];

    logic [COMP_W-1:0] r_red;
    logic [COMP_W-1:0] r_green;
    logic [COMP_W-1:0] r_blue;
    t_item             r_item;
    t_item             n_item;

    logic [COMP_W-1:0]   w_dr;
    logic [COMP_W-1:0]   w_dg;
    logic [COMP_W-1:0]   w_db;
    logic [2*COMP_W-1:0] w_sr;
    logic [2*COMP_W-1:0] w_sg;
    logic [2*COMP_W-1:0] w_sb;
    logic [DIST_W-1:0]   w_dist;
    logic                w_hit;

    // absolute component differences and their squares
    always_comb begin
        w_dr = (r_red   > i_item.red)   ? r_red   - i_item.red   : i_item.red   - r_red;
        w_dg = (r_green > i_item.green) ? r_green - i_item.green : i_item.green - r_green;
        w_db = (r_blue  > i_item.blue)  ? r_blue  - i_item.blue  : i_item.blue  - r_blue;
        w_sr = w_dr * w_dr;
        w_sg = w_dg * w_dg;
        w_sb = w_db * w_db;
        w_dist = DIST_W'(w_sr) + DIST_W'(w_sg) + DIST_W'(w_sb);
    end

    // strict compare keeps the lower index on ties
    always_comb begin
        n_item = i_item;
        if (i_item.kind == KIND_QUERY && w_dist < i_item.distance) begin
            n_item.best     = MY_INDEX;
            n_item.distance = w_dist;
        end
    end

    assign w_hit = i_en && i_item.vld && i_item.kind == KIND_WRITE && i_item.idx == MY_INDEX;

    // stored entry, written when a write beat for this index passes
    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_red   <= i_item.red;
            r_green <= i_item.green;
            r_blue  <= i_item.blue;
        end
    end

    // hand the beat to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

// File: rtl/nearest_palette_color.sv
// nearest_palette_color: nearest palette entry by squared RGB distance
// a beat passes the ingress register, then moves one cell per cycle while the chain is not stalled
// takes one item per cycle while not stalled; writes travel the same chain so order is kept
// the whole chain stalls while a result waits at the output
// reset clears beat valids only; palette entries are undefined until written
`default_nettype none

module nearest_palette_color
    import npc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = NPC_PALETTE_ENTRIES
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output      logic                    o_ready,
    input  wire logic                    i_kind,
    input  wire logic [INDEX_W-1:0]      i_entry_index,
    input  wire logic signed [RAW_W-1:0] i_red,
    input  wire logic signed [RAW_W-1:0] i_green,
    input  wire logic signed [RAW_W-1:0] i_blue,
    output      logic                    o_valid,
    input  wire logic                    i_ready,
    output      logic [INDEX_W-1:0]      o_best_index,
    output      logic [DIST_W-1:0]       o_best_distance
);

    localparam int SEARCH_END = (PALETTE_ENTRIES < NPC_ADDRESSABLE) ?
                                PALETTE_ENTRIES : NPC_ADDRESSABLE;
    localparam int NCELL      = SEARCH_END - 1;

    t_item w_chain [0:NCELL];
    logic  w_en;

    // global advance: hold everything while a result is not taken
    assign w_en    = !(o_valid && !i_ready);
    assign o_ready = w_en;

    npc_ingress u_ingress (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_valid),
        .i_kind        (i_kind),
        .i_entry_index (i_entry_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_item        (w_chain[0])
    );

    // one cell per searched entry
    for (genvar k = 1; k <= NCELL; k++) begin : g_cell
        npc_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_item  (w_chain[k-1]),
            .o_item  (w_chain[k])
        );
    end

    // last cell register is the output register
    assign o_valid         = w_chain[NCELL].vld && w_chain[NCELL].kind == KIND_QUERY;
    assign o_best_index    = w_chain[NCELL].best;
    assign o_best_distance = w_chain[NCELL].distance;

endmodule

`default_nettype wire
